// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for the clocked implication checks used across the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/tdq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer deadline queue package
// Shared types, constants and the ordering function of the timer queue.
// ----------------------------------------------------------------------------
package tdq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int MAX_RESULTS     = 16;
   localparam int TIME_W          = 48;
   localparam int HANDLE_W        = 8;
   localparam int INTERVAL_W      = 32;
   localparam int RES_IDX_W       = $clog2(MAX_RESULTS);
   localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);

   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_EXPIRE = 1'b1;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   typedef struct packed {
      logic                  operation;
      logic [HANDLE_W-1:0]   timer_handle;
      logic [TIME_W-1:0]     expire_at;
      logic [INTERVAL_W-1:0] repeat_interval;
      logic [TIME_W-1:0]     current_time;
   } req_type;

   typedef struct packed {
      logic                fired_valid;
      logic [HANDLE_W-1:0] fired_handle;
      logic                head_changed;
      logic                table_overflow;
      logic                next_valid;
      logic [TIME_W-1:0]   next_deadline;
      logic                last_result;
   } rsp_type;

   typedef struct packed {
      logic                  valid;
      logic                  due;
      logic [TIME_W-1:0]     deadline;
      logic [HANDLE_W-1:0]   handle;
      logic [INTERVAL_W-1:0] interval;
   } entry_type;

   typedef struct packed {
      logic                  mark;
      logic                  shift;
      logic                  ins;
      logic [TIME_W-1:0]     mark_time;
      logic [TIME_W-1:0]     key_deadline;
      logic [HANDLE_W-1:0]   key_handle;
      logic [INTERVAL_W-1:0] key_interval;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD,
      ST_POP,
      ST_EMIT
   } state_type;

   function automatic logic key_less(input logic [TIME_W-1:0]   da,
                                     input logic [HANDLE_W-1:0] ha,
                                     input logic [TIME_W-1:0]   db,
                                     input logic [HANDLE_W-1:0] hb);
      return (da < db) || ((da == db) && (ha < hb));
   endfunction

endpackage

// ===== hw/rtl/tdq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer queue cell
// One slot of the sorted chain: holds a timer, shifts towards the head on a
// pop and makes room for an inserted timer behind all smaller keys.
// ----------------------------------------------------------------------------
module tdq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  tdq_pkg::cell_ctrl_type ctrl,
   input  tdq_pkg::entry_type    left_view,
   input  logic                  left_goes_ahead,
   input  tdq_pkg::entry_type    right_entry,
   output tdq_pkg::entry_type    entry,
   output tdq_pkg::entry_type    view,
   output logic                  goes_ahead
);

   tdq_pkg::entry_type entry_ff;
   tdq_pkg::entry_type entry_in;
   tdq_pkg::entry_type new_entry;

   always_comb begin
      view = ctrl.shift ? right_entry : entry_ff;
      // Entries marked due always stay ahead of a reinserted timer.
      goes_ahead = ctrl.ins && (!view.valid || (!view.due &&
                   tdq_pkg::key_less(ctrl.key_deadline, ctrl.key_handle,
                                     view.deadline, view.handle)));
      new_entry.valid    = 1'b1;
      new_entry.due      = 1'b0;
      new_entry.deadline = ctrl.key_deadline;
      new_entry.handle   = ctrl.key_handle;
      new_entry.interval = ctrl.key_interval;
      entry_in = view;
      priority if (ctrl.mark) begin
         entry_in     = entry_ff;
         entry_in.due = entry_ff.valid && (entry_ff.deadline <= ctrl.mark_time);
      end else if (goes_ahead) begin
         entry_in = left_goes_ahead ? left_view : new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
         entry_ff.due   <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

// ===== hw/rtl/tdq_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer queue chain
// A row of cells kept in ascending (deadline, handle) order, packed at the
// head, with the head entry and the full flag brought out.
// ----------------------------------------------------------------------------
module tdq_chain #(
   parameter int QUEUE_DEPTH = tdq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tdq_pkg::cell_ctrl_type ctrl,
   output tdq_pkg::entry_type    head,
   output logic                  full
);

   tdq_pkg::entry_type entries     [QUEUE_DEPTH];
   tdq_pkg::entry_type views       [QUEUE_DEPTH];
   logic               ahead_flags [QUEUE_DEPTH];

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      tdq_pkg::entry_type left_view;
      tdq_pkg::entry_type right_entry;
      logic               left_goes_ahead;

      if (i == 0) begin : g_first
         assign left_view       = '0;
         assign left_goes_ahead = 1'b0;
      end else begin : g_inner
         assign left_view       = views[i-1];
         assign left_goes_ahead = ahead_flags[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_body
         assign right_entry = entries[i+1];
      end

      tdq_cell u_cell (
         .clock           (clock),
         .reset           (reset),
         .ctrl            (ctrl),
         .left_view       (left_view),
         .left_goes_ahead (left_goes_ahead),
         .right_entry     (right_entry),
         .entry           (entries[i]),
         .view            (views[i]),
         .goes_ahead      (ahead_flags[i])
      );
   end

   assign head = entries[0];
   assign full = entries[QUEUE_DEPTH-1].valid;

endmodule

// ===== hw/rtl/timer_deadline_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer deadline queue
// Bounded timer table kept sorted by (deadline, handle) in a chain of cells.
//
//   Port group  Direction  Handshake            Word
//   req_        in         req_valid/req_ready  tdq_pkg::req_type
//   rsp_        out        rsp_valid/rsp_ready  tdq_pkg::rsp_type
//
// An add word inserts the timer at acceptance, then returns the result.
// An expire word marks due timers at acceptance, pops one due timer a cycle
// from the head while reinserting the previous one, then returns its results.
// Only one word is in progress at a time; a stalled result holds the block.
// Reset clears the chain.
// ----------------------------------------------------------------------------
module timer_deadline_queue #(
   parameter int QUEUE_DEPTH = tdq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tdq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tdq_pkg::rsp_type rsp_data
);

   localparam int CW = tdq_pkg::RES_CNT_W;
   localparam int IW = tdq_pkg::RES_IDX_W;
   localparam int TW = tdq_pkg::TIME_W;

   tdq_pkg::state_type     state_ff, state_in;
   tdq_pkg::cell_ctrl_type ctrl;
   tdq_pkg::entry_type     head;
   logic                   full;

   logic [TW-1:0]                now_ff, now_in;
   logic                         changed_ff, changed_in;
   logic                         overflow_ff, overflow_in;
   logic                         pend_valid_ff, pend_valid_in;
   tdq_pkg::entry_type           pend_ff, pend_in;
   logic [CW-1:0]                nf_ff, nf_in;
   logic [IW-1:0]                rd_ff, rd_in;
   logic [tdq_pkg::HANDLE_W-1:0] res_ff [tdq_pkg::MAX_RESULTS];
   logic                         res_we;
   logic                         rsp_valid_ff, rsp_valid_in;
   tdq_pkg::rsp_type             rsp_data_ff, rsp_data_in;
   logic                         rsp_load;
   logic                         rsp_free;
   logic                         pop;
   logic                         rd_last;
   logic [TW:0]                  reload_sum;
   logic [TW-1:0]                next_deadline;

   tdq_chain #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_chain (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .head  (head),
      .full  (full)
   );

   assign req_ready     = (state_ff == tdq_pkg::ST_IDLE);
   assign rsp_free      = !rsp_valid_ff || rsp_ready;
   assign pop           = head.valid && head.due;
   assign reload_sum    = {1'b0, now_ff} + (TW + 1)'(head.interval);
   assign next_deadline = head.valid ? head.deadline : '0;
   assign rd_last       = (({1'b0, rd_ff}) + CW'(1)) == nf_ff;

   always_comb begin
      state_in      = state_ff;
      ctrl          = '0;
      now_in        = now_ff;
      changed_in    = changed_ff;
      overflow_in   = overflow_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      nf_in         = nf_ff;
      rd_in         = rd_ff;
      res_we        = 1'b0;
      rsp_load      = 1'b0;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         tdq_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_data.operation == tdq_pkg::OP_ADD) begin
                  ctrl.ins          = !full;
                  ctrl.key_deadline = req_data.expire_at;
                  ctrl.key_handle   = req_data.timer_handle;
                  ctrl.key_interval = req_data.repeat_interval;
                  changed_in        = !head.valid || (req_data.expire_at < head.deadline);
                  overflow_in       = full;
                  state_in          = tdq_pkg::ST_ADD;
               end else begin
                  ctrl.mark      = 1'b1;
                  ctrl.mark_time = req_data.current_time;
                  now_in         = req_data.current_time;
                  nf_in          = '0;
                  pend_valid_in  = 1'b0;
                  state_in       = tdq_pkg::ST_POP;
               end
            end
         end
         tdq_pkg::ST_ADD: begin
            if (rsp_free) begin
               rsp_load                   = 1'b1;
               rsp_data_in.fired_valid    = 1'b0;
               rsp_data_in.fired_handle   = '0;
               rsp_data_in.head_changed   = changed_ff && !overflow_ff;
               rsp_data_in.table_overflow = overflow_ff;
               rsp_data_in.next_valid     = head.valid;
               rsp_data_in.next_deadline  = next_deadline;
               rsp_data_in.last_result    = 1'b1;
               state_in                   = tdq_pkg::ST_IDLE;
            end
         end
         tdq_pkg::ST_POP: begin
            ctrl.shift        = pop;
            ctrl.ins          = pend_valid_ff;
            ctrl.key_deadline = pend_ff.deadline;
            ctrl.key_handle   = pend_ff.handle;
            ctrl.key_interval = pend_ff.interval;
            pend_valid_in     = pop && (head.interval != '0);
            pend_in           = head;
            pend_in.deadline  = reload_sum[TW] ? tdq_pkg::TIME_MAX : reload_sum[TW-1:0];
            if (pop && (nf_ff < CW'(tdq_pkg::MAX_RESULTS))) begin
               res_we = 1'b1;
               nf_in  = nf_ff + CW'(1);
            end
            if (!pop && !pend_valid_ff) begin
               rd_in    = '0;
               state_in = tdq_pkg::ST_EMIT;
            end
         end
         tdq_pkg::ST_EMIT: begin
            if (rsp_free) begin
               rsp_load                   = 1'b1;
               rsp_data_in.head_changed   = 1'b0;
               rsp_data_in.table_overflow = 1'b0;
               rsp_data_in.next_valid     = head.valid;
               rsp_data_in.next_deadline  = next_deadline;
               if (nf_ff == '0) begin
                  rsp_data_in.fired_valid  = 1'b0;
                  rsp_data_in.fired_handle = '0;
                  rsp_data_in.last_result  = 1'b1;
                  state_in                 = tdq_pkg::ST_IDLE;
               end else begin
                  rsp_data_in.fired_valid  = 1'b1;
                  rsp_data_in.fired_handle = res_ff[rd_ff];
                  rsp_data_in.last_result  = rd_last;
                  if (rd_last) begin
                     state_in = tdq_pkg::ST_IDLE;
                  end else begin
                     rd_in = rd_ff + IW'(1);
                  end
               end
            end
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tdq_pkg::ST_IDLE;
         pend_valid_ff <= 1'b0;
         nf_ff         <= '0;
         rd_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         nf_ff         <= nf_in;
         rd_ff         <= rd_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      changed_ff  <= changed_in;
      overflow_ff <= overflow_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
      if (res_we) begin
         res_ff[nf_ff[IW-1:0]] <= head.handle;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/tdq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer queue checker
// Port-level checks on the result channel of the timer deadline queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tdq_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input tdq_pkg::rsp_type rsp_data
);

   logic rsp_stall;
   logic rsp_fired;
   logic rsp_plain;
   logic rsp_empty;
   logic rsp_moved;
   logic rsp_flags;
   logic plain_shape;
   logic moved_shape;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_fired   = rsp_valid && rsp_data.fired_valid;
   assign rsp_plain   = rsp_valid && !rsp_data.fired_valid;
   assign rsp_empty   = rsp_valid && !rsp_data.next_valid;
   assign rsp_moved   = rsp_valid && rsp_data.head_changed;
   assign rsp_flags   = rsp_data.head_changed || rsp_data.table_overflow;
   assign plain_shape = rsp_data.last_result && (rsp_data.fired_handle == '0);
   assign moved_shape = rsp_data.next_valid && !rsp_data.table_overflow;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))
   `ASSERT_IMPLY(a_fired_flags, clock, reset, rsp_fired, !rsp_flags)
   `ASSERT_IMPLY(a_empty_deadline, clock, reset, rsp_empty, rsp_data.next_deadline == '0)
   `ASSERT_IMPLY(a_plain_single, clock, reset, rsp_plain, plain_shape)
   `ASSERT_IMPLY(a_changed_held, clock, reset, rsp_moved, moved_shape)

endmodule

bind timer_deadline_queue tdq_checker u_tdq_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/tb_timer_deadline_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer deadline queue testbench
// Drives add and expire words into the timer queue with random gaps on both
// handshakes. A scoreboard keeps its own copy of the timer table, predicts
// every result word and compares the results field by field, in order.
// ----------------------------------------------------------------------------
module tb_timer_deadline_queue;

   localparam int TIME_W      = tdq_pkg::TIME_W;
   localparam int HANDLE_W    = tdq_pkg::HANDLE_W;
   localparam int INTERVAL_W  = tdq_pkg::INTERVAL_W;
   localparam int MAX_RESULTS = tdq_pkg::MAX_RESULTS;
   localparam logic [TIME_W-1:0] TIME_MAX = tdq_pkg::TIME_MAX;

   localparam int TABLE_SLOTS  = tdq_pkg::QUEUE_DEPTH_DEF;
   localparam int RANDOM_WORDS = 200;
   localparam int TAIL_CYCLES  = 64;
   localparam int CYCLE_LIMIT  = 200000;

   class deadline_scoreboard;
      logic [TIME_W-1:0]     tbl_deadline [TABLE_SLOTS];
      logic [HANDLE_W-1:0]   tbl_handle   [TABLE_SLOTS];
      logic [INTERVAL_W-1:0] tbl_interval [TABLE_SLOTS];
      bit                    tbl_busy     [TABLE_SLOTS];
      tdq_pkg::rsp_type      outcome_q [$];
      int                    error_count;

      function new();
         error_count = 0;
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            tbl_busy[i]     = 1'b0;
            tbl_deadline[i] = '0;
            tbl_handle[i]   = '0;
            tbl_interval[i] = '0;
         end
      endfunction

      task report_mismatch(input string what);
         $display("[%0t] mismatch: %s", $time, what);
         error_count++;
      endtask

      function bit earliest_deadline(output logic [TIME_W-1:0] dl);
         bit any;
         any = 1'b0;
         dl  = '0;
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (tbl_busy[i] && (!any || tbl_deadline[i] < dl)) begin
               dl  = tbl_deadline[i];
               any = 1'b1;
            end
         end
         return any;
      endfunction

      function bit store_timer(input logic [TIME_W-1:0]     dl,
                               input logic [HANDLE_W-1:0]   h,
                               input logic [INTERVAL_W-1:0] iv);
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (!tbl_busy[i]) begin
               tbl_busy[i]     = 1'b1;
               tbl_deadline[i] = dl;
               tbl_handle[i]   = h;
               tbl_interval[i] = iv;
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void note_request(input tdq_pkg::req_type w);
         tdq_pkg::rsp_type      r;
         logic [TIME_W-1:0]     cur;
         logic [TIME_W-1:0]     nxt;
         logic [TIME_W:0]       sum;
         logic [HANDLE_W-1:0]   fired_h  [TABLE_SLOTS];
         logic [INTERVAL_W-1:0] fired_iv [TABLE_SLOTS];
         bit                    had;
         bit                    placed;
         bit                    nv;
         int                    nf;
         int                    pick;
         int                    nr;
         r = '0;
         if (w.operation == tdq_pkg::OP_ADD) begin
            had    = earliest_deadline(cur);
            placed = store_timer(w.expire_at, w.timer_handle, w.repeat_interval);
            nv     = earliest_deadline(nxt);
            r.head_changed   = placed && (!had || w.expire_at < cur);
            r.table_overflow = !placed;
            r.next_valid     = nv;
            r.next_deadline  = nxt;
            r.last_result    = 1'b1;
            outcome_q.push_back(r);
            return;
         end
         nf = 0;
         do begin
            pick = -1;
            for (int i = 0; i < TABLE_SLOTS; i++) begin
               if (tbl_busy[i] && tbl_deadline[i] <= w.current_time &&
                   (pick < 0 || tbl_deadline[i] < tbl_deadline[pick] ||
                    (tbl_deadline[i] == tbl_deadline[pick] &&
                     tbl_handle[i] < tbl_handle[pick])))
                  pick = i;
            end
            if (pick >= 0) begin
               fired_h[nf]    = tbl_handle[pick];
               fired_iv[nf]   = tbl_interval[pick];
               tbl_busy[pick] = 1'b0;
               nf++;
            end
         end while (pick >= 0 && nf < TABLE_SLOTS);
         for (int k = 0; k < nf; k++) begin
            if (fired_iv[k] != '0) begin
               sum = {1'b0, w.current_time} +
                     {{(TIME_W + 1 - INTERVAL_W){1'b0}}, fired_iv[k]};
               placed = store_timer(sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0],
                                    fired_h[k], fired_iv[k]);
            end
         end
         nv = earliest_deadline(nxt);
         r.next_valid    = nv;
         r.next_deadline = nxt;
         if (nf == 0) begin
            r.last_result = 1'b1;
            outcome_q.push_back(r);
            return;
         end
         nr = (nf < MAX_RESULTS) ? nf : MAX_RESULTS;
         for (int k = 0; k < nr; k++) begin
            r.fired_valid  = 1'b1;
            r.fired_handle = fired_h[k];
            r.last_result  = (k == nr - 1);
            outcome_q.push_back(r);
         end
      endfunction

      task check_response(input tdq_pkg::rsp_type got);
         tdq_pkg::rsp_type e;
         if (outcome_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result word %h", got));
            return;
         end
         e = outcome_q.pop_front();
         if (got.fired_valid !== e.fired_valid)
            report_mismatch($sformatf("fired_valid %b, expected %b",
                                      got.fired_valid, e.fired_valid));
         if (got.fired_handle !== e.fired_handle)
            report_mismatch($sformatf("fired_handle %h, expected %h",
                                      got.fired_handle, e.fired_handle));
         if (got.head_changed !== e.head_changed)
            report_mismatch($sformatf("head_changed %b, expected %b",
                                      got.head_changed, e.head_changed));
         if (got.table_overflow !== e.table_overflow)
            report_mismatch($sformatf("table_overflow %b, expected %b",
                                      got.table_overflow, e.table_overflow));
         if (got.next_valid !== e.next_valid)
            report_mismatch($sformatf("next_valid %b, expected %b",
                                      got.next_valid, e.next_valid));
         if (got.next_deadline !== e.next_deadline)
            report_mismatch($sformatf("next_deadline %h, expected %h",
                                      got.next_deadline, e.next_deadline));
         if (got.last_result !== e.last_result)
            report_mismatch($sformatf("last_result %b, expected %b",
                                      got.last_result, e.last_result));
      endtask
   endclass

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   tdq_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   tdq_pkg::rsp_type rsp_data;

   deadline_scoreboard  sb;
   bit                  quiet       = 1'b0;
   int                  word_count  = 0;
   int                  rsp_hold    = 0;
   int                  cycle_count = 0;
   logic [TIME_W-1:0]   sim_time    = '0;

   timer_deadline_queue i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int draw_gap();
      return quiet ? 0 : int'($urandom_range(0, 5));
   endfunction

   function automatic logic [TIME_W-1:0] rand48();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[TIME_W-1:0];
   endfunction

   function automatic tdq_pkg::req_type make_add(input logic [HANDLE_W-1:0]   h,
                                                 input logic [TIME_W-1:0]     at,
                                                 input logic [INTERVAL_W-1:0] iv);
      tdq_pkg::req_type w;
      w.operation       = tdq_pkg::OP_ADD;
      w.timer_handle    = h;
      w.expire_at       = at;
      w.repeat_interval = iv;
      w.current_time    = rand48();
      return w;
   endfunction

   function automatic tdq_pkg::req_type make_expire(input logic [TIME_W-1:0] now);
      tdq_pkg::req_type w;
      w.operation       = tdq_pkg::OP_EXPIRE;
      w.timer_handle    = HANDLE_W'($urandom_range(0, 255));
      w.expire_at       = rand48();
      w.repeat_interval = $urandom();
      w.current_time    = now;
      return w;
   endfunction

   function automatic tdq_pkg::req_type random_add();
      logic [HANDLE_W-1:0]   h;
      logic [TIME_W-1:0]     at;
      logic [INTERVAL_W-1:0] iv;
      int                    pick;
      h = ($urandom_range(0, 3) == 0) ? HANDLE_W'($urandom_range(0, 3))
                                      : HANDLE_W'($urandom_range(0, 255));
      at = ($urandom_range(0, 9) == 0) ? rand48()
                                       : sim_time + TIME_W'($urandom_range(0, 400));
      pick = $urandom_range(0, 19);
      if (pick < 10)
         iv = '0;
      else if (pick < 17)
         iv = INTERVAL_W'($urandom_range(1, 300));
      else
         iv = $urandom();
      return make_add(h, at, iv);
   endfunction

   function automatic tdq_pkg::req_type random_expire();
      int pick;
      pick = $urandom_range(0, 9);
      sim_time = sim_time + TIME_W'($urandom_range(0, 300));
      if (pick == 0)
         return make_expire(rand48());
      if (pick == 1)
         return make_expire(TIME_MAX);
      return make_expire(sim_time);
   endfunction

   function automatic tdq_pkg::req_type random_noise();
      tdq_pkg::req_type w;
      w.operation       = 1'($urandom_range(0, 1));
      w.timer_handle    = HANDLE_W'($urandom_range(0, 255));
      w.expire_at       = rand48();
      w.repeat_interval = $urandom();
      w.current_time    = rand48();
      return w;
   endfunction

   task automatic send_word(input tdq_pkg::req_type w);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      word_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         sb.note_request(req_data);
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_response(rsp_data);
         rsp_hold = draw_gap();
      end else if (rsp_hold > 0) begin
         rsp_hold--;
      end
      rsp_ready <= !reset && (rsp_hold == 0);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** timer_deadline_queue: FAILED **");
         $finish;
      end
   end

   initial begin
      int n_add;
      int n_exp;
      int target;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_word(make_expire('0));
      send_word(make_add(8'hFF, TIME_MAX, '0));
      send_word(make_add(8'h00, '0, 32'hFFFF_FFFF));
      send_word(make_add(8'h10, 48'd100, '0));
      send_word(make_add(8'h05, 48'd100, 32'd7));
      send_word(make_add(8'h05, 48'd100, '0));
      for (int i = 0; i < 11; i++)
         send_word(make_add(8'h20 + 8'(i), 48'd200 + 48'(i / 2),
                            (i % 3 != 0) ? 32'(i * 13) : '0));
      send_word(make_add(8'hAA, 48'd1, '0));
      send_word(make_expire(48'd50));
      send_word(make_expire(48'd100));
      send_word(make_add(8'h30, 48'd107, '0));
      send_word(make_expire(TIME_MAX - 48'd3));
      send_word(make_expire(TIME_MAX));

      sim_time = 48'd1000;
      target   = word_count + RANDOM_WORDS;
      while (word_count < target) begin
         quiet = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 11) == 0)
            sim_time = TIME_MAX - TIME_W'($urandom_range(0, 2000));
         else if (sim_time > 48'hFFFF_FFFF_0000)
            sim_time = TIME_W'($urandom_range(0, 5000));
         n_add = $urandom_range(1, 18);
         n_exp = $urandom_range(1, 3);
         for (int i = 0; i < n_add; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_word(random_noise());
            else
               send_word(random_add());
         end
         for (int i = 0; i < n_exp; i++)
            send_word(random_expire());
      end
      req_valid <= 1'b0;

      while (sb.outcome_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.outcome_q.size() != 0)
         sb.report_mismatch("result words still expected at the end");
      if (sb.error_count == 0)
         $display("** timer_deadline_queue: PASSED **");
      else
         $display("** timer_deadline_queue: FAILED **");
      $finish;
   end

endmodule
